// ----- hdl/pgwc_pkg.sv -----
// ----------------------------------------------------------------------------
// Priority grant package
// Shared constants and field widths for the priority grant block and its
// request and response channels.
// ----------------------------------------------------------------------------
package pgwc_pkg;

   // Fixed widths of the channel fields.
   localparam int LEVEL_W = 6;

   // Default sizing of the waiter count store.
   localparam int NUM_LEVELS_DEF = 64;
   localparam int COUNT_BITS_DEF = 8;

   // Request function codes.
   localparam logic FUNC_ACQUIRE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Response status codes.
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

endpackage

// ----- hdl/pgwc_req_if.sv -----
// ----------------------------------------------------------------------------
// Priority grant request channel
// Valid/ready channel carrying one acquire or release request.
// ----------------------------------------------------------------------------
interface pgwc_req_if;

   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [pgwc_pkg::LEVEL_W-1:0] level;

   modport source (output valid, output func, output level, input ready);
   modport sink   (input valid, input func, input level, output ready);

endinterface

// ----- hdl/pgwc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Priority grant response channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface pgwc_rsp_if;

   logic                        valid;
   logic                        ready;
   logic                        granted;
   logic [pgwc_pkg::LEVEL_W-1:0] grant_level;
   logic                        busy_res;
   logic                        status;

   modport source (output valid, output granted, output grant_level, output busy_res,
                   output status, input ready);
   modport sink   (input valid, input granted, input grant_level, input busy_res,
                   input status, output ready);

endinterface

// ----- hdl/priority_grant_with_waiter_counts.sv -----
// ----------------------------------------------------------------------------
// Priority grant with waiter counts
// Fixed-priority arbiter for one shared resource that keeps a count of
// waiters for every priority level in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// A request on req_bus either acquires (func = 0) or releases (func = 1) the
// shared resource. An acquire at a given level is granted at once when the
// resource is free and no level of higher priority (lower number) has
// waiters; otherwise the waiter count of its level is incremented, or, when
// that count is already full, the request is dropped with status = 1. A
// release hands the resource to the highest-priority level with waiters and
// decrements that count; with no waiters the resource becomes free.
// Every request produces exactly one response on rsp_bus.
//
// Timing: a request is accepted in the idle state, the waiter count memory is
// read at that edge into a register, and the update state then performs the
// read-modify-write and loads the response register. A new request is only
// accepted once the previous one has left the update state. A nonzero bitmap
// with a priority encoder picks the first waiting level in the accept cycle.
// The response register holds the result while the receiver stalls; a new
// request is still accepted, but its update waits until the register frees.
// Reset clears the resource to free and the nonzero bitmap to empty at once,
// so no clearing pass over the memory is needed: a level whose bit is clear
// reads as a count of zero.
// ----------------------------------------------------------------------------
module priority_grant_with_waiter_counts #(
   parameter int NUM_LEVELS = pgwc_pkg::NUM_LEVELS_DEF,
   parameter int COUNT_BITS = pgwc_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   pgwc_req_if.sink    req_bus,
   pgwc_rsp_if.source  rsp_bus
);

   localparam int LVL_W = $clog2(NUM_LEVELS);
   localparam int EXT_W = LVL_W + pgwc_pkg::LEVEL_W;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   // Control state.
   state_type              state_ff, state_in;
   logic                   held_ff, held_in;
   logic [NUM_LEVELS-1:0]  nonzero_ff, nonzero_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Captured request and its decisions.
   logic                   func_ff;
   logic [LVL_W-1:0]       tgt_ff;
   logic                   tgt_nonzero_ff;
   logic                   grant_now_ff;
   logic                   has_waiter_ff;

   // Waiter count memory.
   logic [COUNT_BITS-1:0]  count_mem [NUM_LEVELS];
   logic [COUNT_BITS-1:0]  rd_data_ff;
   logic                   wr_en;
   logic [COUNT_BITS-1:0]  wr_data;

   // Response register.
   logic                          rsp_granted_ff, rsp_granted_in;
   logic [pgwc_pkg::LEVEL_W-1:0]  rsp_glevel_ff, rsp_glevel_in;
   logic                          rsp_busy_ff, rsp_busy_in;
   logic                          rsp_status_ff, rsp_status_in;

   // Accept-cycle decode.
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   advance;
   logic [EXT_W-1:0]       level_ext;
   logic                   level_in_range;
   logic [LVL_W-1:0]       lvl_sat;
   logic [LVL_W-1:0]       first_waiter;
   logic                   any_waiter;
   logic                   higher_waiter;
   logic [LVL_W-1:0]       rd_addr;
   logic [COUNT_BITS-1:0]  cur_count;
   logic [EXT_W-1:0]       grant_ext;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;
   // The update may only complete when the response register can take its result.
   assign advance       = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_bus.ready);

   // Levels beyond the configured range fold onto the lowest priority level.
   assign level_ext      = EXT_W'(req_bus.level);
   assign level_in_range = (32'(req_bus.level) < NUM_LEVELS);
   assign lvl_sat        = level_in_range ? level_ext[LVL_W-1:0] : LVL_W'(NUM_LEVELS - 1);

   // Priority encoder over the nonzero bitmap: lowest set index wins.
   always_comb begin
      first_waiter = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonzero_ff[i]) begin
            first_waiter = LVL_W'(i);
         end
      end
   end

   assign any_waiter    = |nonzero_ff;
   assign higher_waiter = any_waiter && (first_waiter < lvl_sat);

   // An acquire touches its own level, a release the first waiting level.
   assign rd_addr = (req_bus.func == pgwc_pkg::FUNC_ACQUIRE) ? lvl_sat : first_waiter;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff        <= req_bus.func;
         tgt_ff         <= rd_addr;
         tgt_nonzero_ff <= nonzero_ff[rd_addr];
         grant_now_ff   <= !held_ff && !higher_waiter;
         has_waiter_ff  <= any_waiter;
      end
   end

   // Synchronous memory: one read at accept, at most one write at the update.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[tgt_ff] <= wr_data;
      end
      if (req_fire) begin
         rd_data_ff <= count_mem[rd_addr];
      end
   end

   // Entries never written are covered by a clear bitmap bit.
   assign cur_count = tgt_nonzero_ff ? rd_data_ff : '0;

   // Read-modify-write and response formation.
   always_comb begin
      wr_en          = 1'b0;
      wr_data        = cur_count;
      held_in        = held_ff;
      nonzero_in     = nonzero_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_glevel_in  = rsp_glevel_ff;
      rsp_busy_in    = rsp_busy_ff;
      rsp_status_in  = rsp_status_ff;
      grant_ext      = EXT_W'(tgt_ff);
      if (advance) begin
         rsp_granted_in = 1'b0;
         rsp_glevel_in  = '0;
         rsp_status_in  = pgwc_pkg::STATUS_OK;
         case (func_ff)
            pgwc_pkg::FUNC_ACQUIRE: begin
               if (grant_now_ff) begin
                  held_in        = 1'b1;
                  rsp_granted_in = 1'b1;
                  rsp_glevel_in  = grant_ext[pgwc_pkg::LEVEL_W-1:0];
               end else if (&cur_count) begin
                  rsp_status_in = pgwc_pkg::STATUS_DROPPED;
               end else begin
                  wr_en              = 1'b1;
                  wr_data            = cur_count + COUNT_BITS'(1);
                  nonzero_in[tgt_ff] = 1'b1;
               end
            end
            default: begin
               if (has_waiter_ff) begin
                  wr_en              = 1'b1;
                  wr_data            = cur_count - COUNT_BITS'(1);
                  nonzero_in[tgt_ff] = (cur_count != COUNT_BITS'(1));
                  held_in            = 1'b1;
                  rsp_granted_in     = 1'b1;
                  rsp_glevel_in      = grant_ext[pgwc_pkg::LEVEL_W-1:0];
               end else begin
                  held_in = 1'b0;
               end
            end
         endcase
         rsp_busy_in = held_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= 1'b0;
         nonzero_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         nonzero_ff   <= nonzero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_granted_ff <= rsp_granted_in;
      rsp_glevel_ff  <= rsp_glevel_in;
      rsp_busy_ff    <= rsp_busy_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.granted     = rsp_granted_ff;
   assign rsp_bus.grant_level = rsp_glevel_ff;
   assign rsp_bus.busy_res    = rsp_busy_ff;
   assign rsp_bus.status      = rsp_status_ff;

   // A grant always leaves the resource held.
   a_grant_holds: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_granted_in |=> rsp_busy_ff && held_ff)
      else $error("grant did not leave resource held");

   // A dropped request never grants anything.
   a_drop_no_grant: assert property (@(posedge clock) disable iff (reset)
      advance && (rsp_status_in == pgwc_pkg::STATUS_DROPPED) |=> !rsp_granted_ff)
      else $error("dropped request reported a grant");

   // The nonzero bitmap tracks every count written back.
   a_bitmap_tracks: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> nonzero_ff[$past(tgt_ff)] == ($past(wr_data) != '0))
      else $error("nonzero bitmap out of step with waiter count");

   // An accepted request is always followed by its update cycle.
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_UPDATE)
      else $error("accepted request did not enter update");

   // No update completes while an untaken response would be overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance |-> !rsp_valid_ff || rsp_bus.ready)
      else $error("response register overwritten");

endmodule
